>>> design/ctc_pkg.sv
// shared types, character codes and helper functions for the cell text type classifier
// no dependencies; imported by ctc_core, cell_text_type_classifier and tb

package ctc_pkg;

   localparam int CHAR_W     = 8;
   localparam int POS_W      = 2;
   localparam int TYPE_W     = 3;
   localparam int RSP_DATA_W = 8;

   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h22;
   localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_POINT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_ONE     = 8'h31;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CH_EQUAL   = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_BSLASH  = 8'h5C;
   localparam logic [CHAR_W-1:0] CH_CARET   = 8'h5E;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

   localparam logic [POS_W-1:0] POS_MAX = 2'd3;
   localparam logic [POS_W-1:0] POS_ONE = 2'd1;
   localparam logic [POS_W-1:0] POS_TWO = 2'd2;

   typedef enum logic [TYPE_W-1:0] {
      TYPE_UNKNOWN = 3'd0,
      TYPE_STRING  = 3'd1,
      TYPE_INTEGER = 3'd2,
      TYPE_DECIMAL = 3'd3,
      TYPE_EMPTY   = 3'd4,
      TYPE_FORMULA = 3'd5
   } field_type_type;

   typedef enum logic [4:0] {
      MODE_START     = 5'b00001,
      MODE_STRING    = 5'b00010,
      MODE_NUMBER    = 5'b00100,
      MODE_FORMULA   = 5'b01000,
      MODE_REFERENCE = 5'b10000
   } parse_mode_type;

   typedef struct packed {
      parse_mode_type   mode;
      logic [POS_W-1:0] pos;
      logic             failed;
      logic             escape_pending;
      logic             point_seen;
      logic             last_op;
      logic             before_last_op;
      logic             ref_nonzero;
      logic             sign_first;
      logic             quote_closed;
      logic             tail_point;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      mode:           MODE_START,
      pos:            '0,
      failed:         1'b0,
      escape_pending: 1'b0,
      point_seen:     1'b0,
      last_op:        1'b0,
      before_last_op: 1'b0,
      ref_nonzero:    1'b0,
      sign_first:     1'b0,
      quote_closed:   1'b0,
      tail_point:     1'b0
   };

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return c inside {[CH_ZERO:CH_NINE]};
   endfunction

   function automatic logic is_op(input logic [CHAR_W-1:0] c);
      return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
   endfunction

   function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] p);
      return (p == POS_MAX) ? p : p + POS_ONE;
   endfunction

endpackage

>>> design/ctc_core.sv
// per-field parse state and its one-character update, plus the end-of-field type decision
// depends on ctc_pkg

module ctc_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_en,
   input  logic [ctc_pkg::CHAR_W-1:0]  char_code,
   input  logic                        char_present,
   input  logic                        field_end,
   output ctc_pkg::field_type_type     result_type
);
   import ctc_pkg::*;

   parse_state_type       state_ff;
   parse_state_type       state_in;
   parse_state_type       upd;
   logic [CHAR_W-1:0]     ch_up;
   logic                  go_on;

   // character update
   always_comb begin
      upd   = state_ff;
      ch_up = char_code;
      go_on = 1'b1;
      if (char_code inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
         ch_up = char_code - CASE_OFFSET;
      end
      if (char_present && !state_ff.failed) begin
         case (state_ff.mode)
            MODE_START: begin
               if (char_code == CH_EQUAL) begin
                  upd.mode = MODE_FORMULA;
               end else if (char_code == CH_QUOTE) begin
                  upd.mode = MODE_STRING;
               end else if (is_digit(char_code)) begin
                  upd.mode = MODE_NUMBER;
               end else if (char_code inside {CH_PLUS, CH_MINUS}) begin
                  upd.mode       = MODE_NUMBER;
                  upd.sign_first = 1'b1;
               end else begin
                  upd.failed = 1'b1;
               end
               upd.pos = bump(state_ff.pos);
            end
            MODE_STRING: begin
               if (state_ff.quote_closed) begin
                  upd.failed = 1'b1;
               end else if (state_ff.escape_pending) begin
                  if (char_code inside {CH_BSLASH, CH_QUOTE}) begin
                     upd.escape_pending = 1'b0;
                  end else begin
                     upd.failed = 1'b1;
                  end
               end else if (char_code == CH_QUOTE) begin
                  upd.quote_closed = 1'b1;
               end else if (char_code == CH_BSLASH) begin
                  upd.escape_pending = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (char_code == CH_POINT) begin
                  if (state_ff.point_seen ||
                      (state_ff.pos == POS_ONE && state_ff.sign_first)) begin
                     upd.failed = 1'b1;
                  end else begin
                     upd.point_seen = 1'b1;
                     upd.tail_point = 1'b1;
                     upd.pos        = bump(state_ff.pos);
                  end
               end else if (is_digit(char_code)) begin
                  upd.tail_point = 1'b0;
                  upd.pos        = bump(state_ff.pos);
               end else begin
                  upd.failed = 1'b1;
               end
            end
            MODE_FORMULA, MODE_REFERENCE: begin
               if (char_code != CH_SPACE) begin
                  // inside a reference anything but an operator extends it
                  if (state_ff.mode == MODE_REFERENCE) begin
                     go_on = 1'b0;
                     if (!is_op(ch_up)) begin
                        if (ch_up inside {[CH_ONE:CH_NINE]}) begin
                           upd.ref_nonzero = 1'b1;
                        end
                        upd.tail_point     = 1'b0;
                        upd.before_last_op = state_ff.last_op;
                        upd.last_op        = 1'b0;
                        upd.pos            = bump(state_ff.pos);
                     end else if (!state_ff.ref_nonzero) begin
                        upd.failed = 1'b1;
                     end else begin
                        upd.mode = MODE_FORMULA;
                        go_on    = 1'b1;
                     end
                  end
                  if (go_on) begin
                     if (ch_up inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
                        upd.mode           = MODE_REFERENCE;
                        upd.ref_nonzero    = 1'b0;
                        upd.tail_point     = 1'b0;
                        upd.before_last_op = state_ff.last_op;
                        upd.last_op        = 1'b0;
                        upd.pos            = bump(state_ff.pos);
                     end else if (is_op(ch_up)) begin
                        if (state_ff.last_op && (state_ff.before_last_op ||
                            ch_up inside {CH_STAR, CH_SLASH, CH_CARET})) begin
                           upd.failed = 1'b1;
                        end else begin
                           upd.tail_point     = 1'b0;
                           upd.before_last_op = state_ff.last_op;
                           upd.last_op        = 1'b1;
                           upd.pos            = bump(state_ff.pos);
                        end
                     end else if (is_digit(ch_up)) begin
                        upd.tail_point     = 1'b0;
                        upd.before_last_op = state_ff.last_op;
                        upd.last_op        = 1'b0;
                        upd.pos            = bump(state_ff.pos);
                     end else if (ch_up == CH_POINT) begin
                        if (state_ff.last_op || state_ff.pos == POS_ONE) begin
                           upd.failed = 1'b1;
                        end else begin
                           upd.tail_point     = 1'b1;
                           upd.before_last_op = state_ff.last_op;
                           upd.last_op        = 1'b0;
                           upd.pos            = bump(state_ff.pos);
                        end
                     end else begin
                        upd.failed = 1'b1;
                     end
                  end
               end
            end
            default: begin
               upd = state_ff;
            end
         endcase
      end
   end

   // type decision on the updated state
   always_comb begin
      result_type = TYPE_UNKNOWN;
      if (!upd.failed) begin
         case (upd.mode)
            MODE_START: begin
               result_type = TYPE_EMPTY;
            end
            MODE_STRING: begin
               if (upd.quote_closed && !upd.escape_pending) begin
                  result_type = TYPE_STRING;
               end
            end
            MODE_NUMBER: begin
               if (!(upd.tail_point || (upd.pos == POS_ONE && upd.sign_first))) begin
                  result_type = upd.point_seen ? TYPE_DECIMAL : TYPE_INTEGER;
               end
            end
            MODE_REFERENCE: begin
               if (upd.ref_nonzero) begin
                  result_type = TYPE_FORMULA;
               end
            end
            MODE_FORMULA: begin
               if (!(upd.pos < POS_TWO || upd.last_op || upd.tail_point)) begin
                  result_type = TYPE_FORMULA;
               end
            end
            default: begin
               result_type = TYPE_UNKNOWN;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      if (step_en) begin
         state_in = field_end ? STATE_RESET : upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/cell_text_type_classifier.sv
// top level of the cell text type classifier: input register, parse core, result register
// depends on ctc_pkg and ctc_core

// Classifies one spreadsheet field that arrives one character per transaction on the
// req_ channel and returns one type code on the rsp_ channel for each transaction that
// carries req_tlast. Codes: 0 unknown, 1 quoted string, 2 integer, 3 decimal, 4 empty,
// 5 formula. req_tuser[0] marks req_tdata as a real character; a transaction with it low
// and req_tlast high closes the field with what came before (an empty field if nothing
// did), and with both low it does nothing. Throughput is one transaction per clock: each
// character goes from the input register through the combinational parse update in
// ctc_core into the parse state, and at the field end into the result register, which
// drives the type code on rsp_tdata. Only field-end transactions wait for rsp_tready; a
// result still waiting in the result register stalls the input only once the next field
// end reaches the input register.

module cell_text_type_classifier (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ctc_pkg::CHAR_W-1:0]     req_tdata,   // [7:0] char_code
   input  logic [0:0]                     req_tuser,   // [0] char_present
   input  logic                           req_tlast,   // field_end
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ctc_pkg::RSP_DATA_W-1:0] rsp_tdata    // [2:0] field_type, [7:3] zero
);
   import ctc_pkg::*;

   // input register stage
   logic              in_valid_ff,   in_valid_in;
   logic [CHAR_W-1:0] in_char_ff,    in_char_in;
   logic              in_present_ff, in_present_in;
   logic              in_last_ff,    in_last_in;

   // result register stage
   logic              rsp_valid_ff,  rsp_valid_in;
   field_type_type    rsp_type_ff,   rsp_type_in;

   logic              advance;
   logic              req_take;
   field_type_type    core_type;

   // an item moves on unless it closes a field while the result register is still full
   assign advance  = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take = req_tvalid && req_tready;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_char_in    = in_char_ff;
      in_present_in = in_present_ff;
      in_last_in    = in_last_ff;
      if (req_take) begin
         in_valid_in   = 1'b1;
         in_char_in    = req_tdata;
         in_present_in = req_tuser[0];
         in_last_in    = req_tlast;
      end else if (advance) begin
         in_valid_in   = 1'b0;
      end
   end

   ctc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .char_code    (in_char_ff),
      .char_present (in_present_ff),
      .field_end    (in_last_ff),
      .result_type  (core_type)
   );

   // result register: load on a field end, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_type_in  = rsp_type_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_type_in  = core_type;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      in_char_ff    <= in_char_in;
      in_present_ff <= in_present_in;
      in_last_ff    <= in_last_in;
      rsp_type_ff   <= rsp_type_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-TYPE_W){1'b0}}, rsp_type_ff};

   // a field end never overwrites a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(advance && in_last_ff && rsp_valid_ff && !rsp_tready))
      else $error("field end advanced over a pending result");

   // a result only appears after a field end left the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && in_last_ff))
      else $error("result appeared without a field end");

   // an empty field right after a completed field reports empty
   a_empty_field: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) ##1 (advance && in_last_ff && !in_present_ff)
      |=> rsp_valid_ff && (rsp_type_ff == TYPE_EMPTY))
      else $error("empty field not reported as empty");

endmodule

>>> verif/tb.sv
// self-checking testbench for cell_text_type_classifier: directed fields, backpressure, random
// fields; depends on ctc_pkg for character codes, type codes and the parse state layout

module tb;
   import ctc_pkg::*;

   localparam int RUN_LIMIT       = 400000;  // time units, far above the slowest correct run
   localparam int DRAIN_CYCLES    = 10;      // margin for the last responses to drain
   localparam int RSP_HOLD_CYCLES = 300;     // long receiver hold-off for the pressure test
   localparam int PRINT_CAP       = 50;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel, driven from the start with known values
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CHAR_W-1:0]     req_tdata  = '0;
   logic [0:0]            req_tuser  = '0;
   logic                  req_tlast  = 1'b0;

   // response channel
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // idling knobs, in percent of cycles
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;

   // receiver hold-off request: the pressure test bumps hold_go, the receiver counts
   int hold_go    = 0;
   int hold_taken = 0;
   int hold_left  = 0;

   int items_sent     = 0;
   int mismatch_count = 0;

   // shadow copy of the parse state and the type codes still owed by the block
   parse_state_type shadow = STATE_RESET;
   field_type_type  field_types_due[$];

   // characters of the field being built
   logic [CHAR_W-1:0] field_chars[$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   cell_text_type_classifier u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] char_code
      .req_tuser  (req_tuser),   // [0] char_present
      .req_tlast  (req_tlast),   // field_end
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // [2:0] field_type, [7:3] zero
   );

   // ------------------------------------------------------------------
   // type prediction
   // ------------------------------------------------------------------

   function automatic logic digit_char(input logic [CHAR_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic op_char(input logic [CHAR_W-1:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
             (c == CH_SLASH) || (c == CH_CARET);
   endfunction

   // character counter saturates at three
   function automatic void count_char();
      if (shadow.pos != POS_MAX) shadow.pos = shadow.pos + POS_ONE;
   endfunction

   // two-deep history of operator characters inside a formula
   function automatic void push_op_flag(input logic now_op);
      shadow.before_last_op = shadow.last_op;
      shadow.last_op        = now_op;
   endfunction

   function automatic void absorb_formula_char(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] c;
      c = ch;
      // spaces vanish, lower case folds to upper case
      if (c == CH_SPACE) return;
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CASE_OFFSET;
      if (shadow.mode == MODE_REFERENCE) begin
         // a reference swallows everything up to the next operator
         if (!op_char(c)) begin
            if (c >= CH_ONE && c <= CH_NINE) shadow.ref_nonzero = 1'b1;
            shadow.tail_point = 1'b0;
            push_op_flag(1'b0);
            count_char();
            return;
         end
         if (!shadow.ref_nonzero) begin
            shadow.failed = 1'b1;
            return;
         end
         shadow.mode = MODE_FORMULA;
      end
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         shadow.mode        = MODE_REFERENCE;
         shadow.ref_nonzero = 1'b0;
         shadow.tail_point  = 1'b0;
         push_op_flag(1'b0);
      end else if (op_char(c)) begin
         // second operator in a run only as a sign, never a third
         if (shadow.last_op && (shadow.before_last_op || c == CH_STAR ||
                                c == CH_SLASH || c == CH_CARET)) begin
            shadow.failed = 1'b1;
            return;
         end
         shadow.tail_point = 1'b0;
         push_op_flag(1'b1);
      end else if (digit_char(c)) begin
         shadow.tail_point = 1'b0;
         push_op_flag(1'b0);
      end else if (c == CH_POINT) begin
         // no point after an operator or right after the equal sign
         if (shadow.last_op || shadow.pos == POS_ONE) begin
            shadow.failed = 1'b1;
            return;
         end
         shadow.tail_point = 1'b1;
         push_op_flag(1'b0);
      end else begin
         shadow.failed = 1'b1;
         return;
      end
      count_char();
   endfunction

   function automatic void absorb_char(input logic [CHAR_W-1:0] c);
      if (shadow.failed) return;
      case (shadow.mode)
         MODE_START: begin
            if (c == CH_EQUAL) shadow.mode = MODE_FORMULA;
            else if (c == CH_QUOTE) shadow.mode = MODE_STRING;
            else if (digit_char(c)) shadow.mode = MODE_NUMBER;
            else if (c == CH_PLUS || c == CH_MINUS) begin
               shadow.mode       = MODE_NUMBER;
               shadow.sign_first = 1'b1;
            end else shadow.failed = 1'b1;
            count_char();
         end
         MODE_STRING: begin
            // nothing may follow the closing quote
            if (shadow.quote_closed) shadow.failed = 1'b1;
            else if (shadow.escape_pending) begin
               if (c == CH_BSLASH || c == CH_QUOTE) shadow.escape_pending = 1'b0;
               else shadow.failed = 1'b1;
            end else if (c == CH_QUOTE) shadow.quote_closed = 1'b1;
            else if (c == CH_BSLASH) shadow.escape_pending = 1'b1;
         end
         MODE_NUMBER: begin
            if (c == CH_POINT) begin
               if (shadow.point_seen || (shadow.pos == POS_ONE && shadow.sign_first)) begin
                  shadow.failed = 1'b1;
               end else begin
                  shadow.point_seen = 1'b1;
                  shadow.tail_point = 1'b1;
                  count_char();
               end
            end else if (digit_char(c)) begin
               shadow.tail_point = 1'b0;
               count_char();
            end else shadow.failed = 1'b1;
         end
         default: absorb_formula_char(c);
      endcase
   endfunction

   function automatic field_type_type closing_type();
      if (shadow.failed) return TYPE_UNKNOWN;
      case (shadow.mode)
         MODE_START: return TYPE_EMPTY;
         MODE_STRING: begin
            if (shadow.quote_closed && !shadow.escape_pending) return TYPE_STRING;
            return TYPE_UNKNOWN;
         end
         MODE_NUMBER: begin
            // a lone sign or a trailing point is no number
            if (shadow.tail_point || (shadow.pos == POS_ONE && shadow.sign_first))
               return TYPE_UNKNOWN;
            if (shadow.point_seen) return TYPE_DECIMAL;
            return TYPE_INTEGER;
         end
         MODE_REFERENCE: begin
            if (shadow.ref_nonzero) return TYPE_FORMULA;
            return TYPE_UNKNOWN;
         end
         default: begin
            if (shadow.pos < POS_TWO || shadow.last_op || shadow.tail_point)
               return TYPE_UNKNOWN;
            return TYPE_FORMULA;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // append one character to the field being built
   function automatic void add_char(input logic [CHAR_W-1:0] c);
      field_chars.insert(field_chars.size(), c);
   endfunction

   // remove the last character of the field being built
   function automatic void drop_last_char();
      field_chars.delete(field_chars.size() - 1);
   endfunction

   function automatic logic [CHAR_W-1:0] rand_byte();
      return CHAR_W'($urandom_range(255));
   endfunction

   function automatic logic [CHAR_W-1:0] char_offset(input logic [CHAR_W-1:0] base,
                                                     input int unsigned span);
      return base + CHAR_W'($urandom_range(span));
   endfunction

   function automatic logic [CHAR_W-1:0] rand_letter();
      return char_offset($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A, 25);
   endfunction

   function automatic logic [CHAR_W-1:0] rand_op();
      case ($urandom_range(4))
         0:       return CH_PLUS;
         1:       return CH_MINUS;
         2:       return CH_STAR;
         3:       return CH_SLASH;
         default: return CH_CARET;
      endcase
   endfunction

   // characters that sit on the edges of the grammar
   function automatic logic [CHAR_W-1:0] rand_special();
      case ($urandom_range(8))
         0:       return CH_POINT;
         1:       return rand_op();
         2:       return CH_QUOTE;
         3:       return CH_BSLASH;
         4:       return CH_EQUAL;
         5:       return CH_SPACE;
         6:       return CH_ZERO;
         7:       return rand_letter();
         default: return rand_byte();
      endcase
   endfunction

   // mostly well-formed strings, numbers and formulas, some noise, some broken ones
   function automatic void build_random_field();
      int unsigned kind;
      int unsigned terms;
      field_chars.delete();
      kind = $urandom_range(99);
      if (kind < 22) begin
         // quoted string with escapes
         add_char(CH_QUOTE);
         repeat ($urandom_range(6)) begin
            case ($urandom_range(5))
               0: begin
                  add_char(CH_BSLASH);
                  add_char($urandom_range(1) ? CH_QUOTE : CH_BSLASH);
               end
               1:       add_char(CH_SPACE);
               2:       add_char(char_offset(CH_ZERO, 9));
               default: add_char(rand_letter());
            endcase
         end
         add_char(CH_QUOTE);
      end else if (kind < 44) begin
         // number with optional sign and fraction
         case ($urandom_range(3))
            0:       add_char(CH_PLUS);
            1:       add_char(CH_MINUS);
            default: ;
         endcase
         repeat ($urandom_range(4, 1)) add_char(char_offset(CH_ZERO, 9));
         if ($urandom_range(1)) begin
            add_char(CH_POINT);
            repeat ($urandom_range(3, 1)) add_char(char_offset(CH_ZERO, 9));
         end
      end else if (kind < 80) begin
         // formula: terms joined by operators, spaces sprinkled in
         add_char(CH_EQUAL);
         terms = $urandom_range(3, 1);
         for (int t = 0; t < terms; t++) begin
            if (t > 0) begin
               add_char(rand_op());
               if ($urandom_range(3) == 0)
                  add_char($urandom_range(1) ? CH_PLUS : CH_MINUS);
            end
            if ($urandom_range(3) == 0) add_char(CH_SPACE);
            if ($urandom_range(1)) begin
               // cell reference, sometimes with only zeros
               add_char(rand_letter());
               if ($urandom_range(3) == 0) add_char(rand_letter());
               if ($urandom_range(5) == 0) add_char(CH_ZERO);
               else add_char(char_offset(CH_ONE, 8));
               if ($urandom_range(1)) add_char(char_offset(CH_ZERO, 9));
            end else begin
               repeat ($urandom_range(3, 1)) add_char(char_offset(CH_ZERO, 9));
               if ($urandom_range(3) == 0) begin
                  add_char(CH_POINT);
                  add_char(char_offset(CH_ZERO, 9));
               end
            end
            if ($urandom_range(5) == 0) add_char(CH_SPACE);
         end
      end else begin
         // raw byte noise
         repeat ($urandom_range(5, 1)) add_char(rand_byte());
      end
      // break about one well-formed field in five
      if (kind < 80 && $urandom_range(4) == 0) begin
         case ($urandom_range(2))
            0: field_chars[$urandom_range(field_chars.size() - 1)] = rand_special();
            1: if (field_chars.size() > 1) drop_last_char();
            default: add_char(rand_special());
         endcase
      end
   endfunction

   // ------------------------------------------------------------------
   // transaction driving and checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_CAP) $display("tb: mismatch: %s", msg);
      mismatch_count++;
   endtask

   // offer one transaction, wait for the handshake, then update the shadow state
   task automatic send_item(input logic [CHAR_W-1:0] ch, input logic present,
                            input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= ch;
      req_tuser[0] <= present;
      req_tlast    <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (present) absorb_char(ch);
      if (last) begin
         field_types_due.insert(field_types_due.size(), closing_type());
         shadow = STATE_RESET;
      end
   endtask

   // send field_chars; sometimes close with a separate no-character transaction,
   // sometimes slip no-character transactions in between
   task automatic send_field(input int unsigned close_apart_pct, input int unsigned blank_pct);
      logic apart;
      int   n;
      n     = field_chars.size();
      apart = ($urandom_range(99) < close_apart_pct) || (n == 0);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < blank_pct) send_item(rand_byte(), 1'b0, 1'b0);
         send_item(field_chars[i], 1'b1, !apart && (i == n - 1));
      end
      if (apart) send_item(rand_byte(), 1'b0, 1'b1);
   endtask

   task automatic send_text(input string s, input logic close_apart = 1'b0,
                            input logic blank_inside = 1'b0);
      field_chars.delete();
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
      send_field(close_apart ? 100 : 0, blank_inside ? 100 : 0);
   endtask

   // receiver: random stalls, or a long hold-off counted here when asked for
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_go != hold_taken) begin
         hold_taken <= hold_go;
         hold_left  <= RSP_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // every response transaction is matched against the oldest pending type code
   always @(posedge clock) begin
      field_type_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (field_types_due.size() == 0) begin
            report_mismatch($sformatf("response 0x%02h with no field pending", rsp_tdata));
         end else begin
            want = field_types_due.pop_front();
            if (rsp_tdata[TYPE_W-1:0] !== want)
               report_mismatch($sformatf("field_type %0d, predicted %0d (%s)",
                                         rsp_tdata[TYPE_W-1:0], want, want.name()));
            if (rsp_tdata[RSP_DATA_W-1:TYPE_W] !== '0)
               report_mismatch($sformatf("padding bits 0x%02h not zero", rsp_tdata));
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // one field per rule of the grammar
   task automatic test_directed();
      send_text("");                       // empty field
      send_text("\"\"");                   // empty quoted string
      send_text("\"a\\\"b\\\\\"");         // both escape pairs
      send_text("\"ab\"c");                // text after closing quote
      send_text("\"a\\x\"");               // bad escape
      send_text("\"abc");                  // unterminated
      send_text("7");
      send_text("-12");
      send_text("+");                      // sign alone
      send_text("-.5");                    // sign then point
      send_text("3.14");
      send_text("1.");                     // trailing point
      send_text("1.2.3");                  // two points in a number
      send_text("12", 1'b1, 1'b1);         // blanks inside, closed without character
      send_text("=A1+b2*3");
      send_text("= a1 - -2");              // spaces, lower case, sign after operator
      send_text("=1+--2");                 // three operators
      send_text("=1+*2");                  // star after operator
      send_text("=.5");                    // point right after equal sign
      send_text("=ab0c1");                 // reference with letters inside
      send_text("=a0+1");                  // reference without nonzero digit
      send_text("=1.2.3^2");               // several points in a formula number
      send_text("=1+");                    // ends in operator
      send_text("=");                      // nothing after equal sign
      field_chars = '{8'hFF, 8'h00, 8'h80};  // bytes at both ends of the range
      send_field(0, 0);
   endtask

   // hold the receiver off while the sender keeps offering, so the input stalls
   task automatic test_input_stall();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_go <= hold_go + 1;
      repeat (30) begin
         build_random_field();
         send_field(10, 4);
      end
   endtask

   task automatic test_random(input int unsigned send_pct, input int unsigned stall_pct,
                              input int count);
      int target;
      target             = items_sent + count;
      sender_idle_pct    = send_pct;
      receiver_stall_pct = stall_pct;
      while (items_sent < target) begin
         build_random_field();
         send_field(10, 4);
      end
   endtask

   // run limit
   initial begin
      #(RUN_LIMIT);
      $display("tb: failure");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_input_stall();
      test_random(0, 0, 400);     // no idling
      test_random(65, 0, 380);    // sender mostly idle
      test_random(0, 65, 380);    // receiver mostly stalled
      test_random(29, 29, 420);   // both

      // drain: stop offering, let the receiver take everything
      req_tvalid <= 1'b0;
      receiver_stall_pct = 0;
      while (field_types_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
